// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, skipped while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mvmh_pkg.sv =====
`default_nettype none

package mvmh_pkg;

  localparam int MAX_LENGTH_DEF = 64;

  localparam int IDX_W    = 6;
  localparam int MULT_W   = 64;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 7;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HASH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ADD_OFFSET    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b1;

  localparam logic [WORD_W-1:0] MIX_C0 = 32'hed5ad4bb;
  localparam logic [WORD_W-1:0] MIX_C1 = 32'hac4c1b51;
  localparam logic [WORD_W-1:0] MIX_C2 = 32'h31848bab;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX0,
    S_MIX1,
    S_MIX2,
    S_MUL,
    S_ACC
  } step_t;

  typedef enum logic [1:0] {
    SH_17,
    SH_11,
    SH_15,
    SH_14
  } shift_sel_t;

  typedef enum logic [1:0] {
    CF_C0,
    CF_C1,
    CF_C2,
    CF_TBL
  } coef_sel_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT,
    J_END
  } jump_t;

  typedef struct packed {
    logic       take;
    logic       mul_en;
    shift_sel_t sh;
    coef_sel_t  coef;
    logic       tbl_rd;
    logic       acc;
    jump_t      jmp;
    step_t      nxt;
  } ctrl_t;

  // control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{take: 1'b0, mul_en: 1'b0, sh: SH_17, coef: CF_C0, tbl_rd: 1'b0,
          acc: 1'b0, jmp: J_WAIT, nxt: S_IDLE};
    case (s)
      S_IDLE: begin
        w.take = 1'b1;
        w.jmp  = J_WAIT;
      end
      S_MIX0: begin
        w.mul_en = 1'b1;
        w.sh     = SH_17;
        w.coef   = CF_C0;
        w.jmp    = J_NEXT;
        w.nxt    = S_MIX1;
      end
      S_MIX1: begin
        w.mul_en = 1'b1;
        w.sh     = SH_11;
        w.coef   = CF_C1;
        w.jmp    = J_NEXT;
        w.nxt    = S_MIX2;
      end
      S_MIX2: begin
        w.mul_en = 1'b1;
        w.sh     = SH_15;
        w.coef   = CF_C2;
        w.tbl_rd = 1'b1;
        w.jmp    = J_NEXT;
        w.nxt    = S_MUL;
      end
      S_MUL: begin
        w.mul_en = 1'b1;
        w.sh     = SH_14;
        w.coef   = CF_TBL;
        w.jmp    = J_NEXT;
        w.nxt    = S_ACC;
      end
      S_ACC: begin
        w.take = 1'b1;
        w.acc  = 1'b1;
        w.jmp  = J_END;
      end
      default: begin
        w.jmp = J_NEXT;
        w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mvmh_seq.sv =====
`default_nettype none

module mvmh_seq (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              blocked,
  output mvmh_pkg::ctrl_t  ctrl
);
  import mvmh_pkg::*;

  step_t step_r;
  step_t step_nxt;

  always_comb begin
    ctrl = ucode(step_r);
  end

  always_comb begin
    step_nxt = step_r;
    case (ctrl.jmp)
      J_NEXT: begin
        step_nxt = ctrl.nxt;
      end
      J_WAIT: begin
        step_nxt = start ? S_MIX0 : S_IDLE;
      end
      J_END: begin
        if (blocked) begin
          step_nxt = S_ACC;
        end else begin
          step_nxt = start ? S_MIX0 : S_IDLE;
        end
      end
      default: begin
        step_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mixed_vector_multiply_hash.sv =====
`default_nettype none

// Vector hash: each request either loads a multiplier into the table (taken
// whenever the block is idle) or carries one 32-bit key word. A key word is mixed by four
// passes through one shared 32x32 multiplier, stepped by a small control store, and then
// accumulated; the accumulate step overlaps the acceptance of the next request, so a
// steady stream of key words need not wait for an idle step. The result appears in an
// output register, so a stalled result does not hold up further input unless a second
// vector end has to wait for it. Only the low 32 bits of the multipliers and of the
// starting offset reach the result, and only those are stored. Table entries read
// before they are loaded give undefined results.
module mixed_vector_multiply_hash #(
  parameter int MAX_LENGTH = mvmh_pkg::MAX_LENGTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_opcode,
  input  wire  [mvmh_pkg::IDX_W-1:0]          in_entry_index,
  input  wire  [mvmh_pkg::MULT_W-1:0]         in_multiplier,
  input  wire  [mvmh_pkg::WORD_W-1:0]         in_key_word,
  input  wire                                 in_last,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [mvmh_pkg::WORD_W-1:0]         out_hash_key,
  output logic                                out_length_error,
  input  wire                                 cfg_we,
  input  wire  [mvmh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mvmh_pkg::CFG_W-1:0]          cfg_wdata
);
  import mvmh_pkg::*;

  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int XW = (AW > CNT_W) ? AW : CNT_W;

  ctrl_t ctrl;

  logic [WORD_W-1:0] offset_r;
  logic [CNT_W-1:0]  vlen_r;

  logic [WORD_W-1:0] x_r;
  logic              last_r;
  logic [WORD_W-1:0] sum_r;
  logic [CNT_W-1:0]  pos_r;
  logic              ovr_r;
  logic [WORD_W-1:0] tbl_rd_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_hash_key_r;
  logic              out_length_error_r;

  logic [WORD_W-1:0] tbl_mem [MAX_LENGTH];

  logic              blocked;
  logic              in_take;
  logic              in_acc;
  logic              hash_start;
  logic              load_we;
  logic              acc_fire;
  logic [XW-1:0]     rd_ext;
  logic [XW-1:0]     wr_ext;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] mix_in;
  logic [WORD_W-1:0] coef;
  logic [WORD_W-1:0] prod;

  logic              first;
  logic              in_range;
  logic [CNT_W-1:0]  pos_new;
  logic              ovr_new;
  logic [WORD_W-1:0] sum_base;
  logic [WORD_W-1:0] sum_new;
  logic              err;

  mvmh_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .blocked (blocked),
    .ctrl    (ctrl)
  );

  // a vector end cannot retire while the previous result is still held
  assign blocked    = ctrl.acc && last_r && out_valid_r && out_stall;
  assign in_take    = ctrl.take && !blocked;
  assign in_stall   = !in_take;
  assign in_acc     = in_valid && in_take;
  assign hash_start = in_acc && (in_opcode == OP_HASH);
  assign load_we    = in_acc && (in_opcode == OP_LOAD) && (int'(in_entry_index) < MAX_LENGTH);
  assign acc_fire   = ctrl.acc && !blocked;

  assign rd_ext  = XW'(pos_r);
  assign wr_ext  = XW'(in_entry_index);
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (load_we) begin
      tbl_mem[wr_addr] <= in_multiplier[WORD_W-1:0];
    end
    if (ctrl.tbl_rd) begin
      tbl_rd_r <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      vlen_r   <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADD_OFFSET:    offset_r <= cfg_wdata[WORD_W-1:0];
        CFG_VECTOR_LENGTH: vlen_r   <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // xor-shift then multiply, one pass per step
  always_comb begin
    case (ctrl.sh)
      SH_17:   mix_in = x_r ^ (x_r >> 17);
      SH_11:   mix_in = x_r ^ (x_r >> 11);
      SH_15:   mix_in = x_r ^ (x_r >> 15);
      SH_14:   mix_in = x_r ^ (x_r >> 14);
      default: mix_in = x_r;
    endcase
    case (ctrl.coef)
      CF_C0:   coef = MIX_C0;
      CF_C1:   coef = MIX_C1;
      CF_C2:   coef = MIX_C2;
      CF_TBL:  coef = tbl_rd_r;
      default: coef = MIX_C0;
    endcase
  end

  assign prod = mix_in * coef;

  always_ff @(posedge clk) begin
    if (hash_start) begin
      x_r    <= in_key_word + WORD_W'(1);
      last_r <= in_last;
    end else if (ctrl.mul_en) begin
      x_r <= prod;
    end
  end

  // position bookkeeping and the sum are settled in the accumulate step
  always_comb begin
    first    = (pos_r == '0) && !ovr_r;
    in_range = (pos_r < vlen_r) && (int'(pos_r) < MAX_LENGTH);
    pos_new  = in_range ? pos_r + CNT_W'(1) : pos_r;
    ovr_new  = ovr_r || !in_range;
    sum_base = first ? offset_r : sum_r;
    sum_new  = sum_base + (in_range ? x_r : '0);
    err      = ovr_new || (vlen_r == '0) || (int'(vlen_r) > MAX_LENGTH) ||
               (pos_new != vlen_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovr_r <= 1'b0;
    end else if (acc_fire) begin
      if (last_r) begin
        pos_r <= '0;
        ovr_r <= 1'b0;
      end else begin
        pos_r <= pos_new;
        ovr_r <= ovr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      sum_r <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_fire && last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && last_r) begin
      out_hash_key_r     <= err ? '0 : sum_new;
      out_length_error_r <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hash_key     = out_hash_key_r;
  assign out_length_error = out_length_error_r;

endmodule

`default_nettype wire

// ===== rtl/mvmh_check.sv =====
`default_nettype none

`include "assert_macros.svh"

module mvmh_check (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              in_opcode,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [mvmh_pkg::WORD_W-1:0]       out_hash_key,
  input wire                              out_length_error
);
  import mvmh_pkg::*;

  logic hash_req;

  assign hash_req = in_valid && !in_stall && (in_opcode == OP_HASH);

  // a key word keeps the input closed while the mixer runs
  `ASSERT_NEXT(a_mix_busy, clk, rst_n, hash_req, in_stall ##1 in_stall ##1 in_stall ##1 in_stall)

  // a length error always comes with a zero key
  `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_length_error, out_hash_key == '0)

  // a held result stays up
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // reset drops any pending result
  `ASSERT_NEXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid)

endmodule

bind mixed_vector_multiply_hash mvmh_check u_check (.*);

`default_nettype wire
